FILE: src/fva_pkg.sv
package fva_pkg;

  localparam int CLIENTS = 8;
  localparam int LEVELS  = 16;

  localparam int CIDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W  = $clog2(((CLIENTS > LEVELS) ? CLIENTS : LEVELS) + 1);

  localparam logic [31:0] U32_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] LATENCY_RST = 32'd10000;

  typedef enum logic [2:0] {
    ACT_TBL_WR = 3'd0,
    ACT_OPEN   = 3'd1,
    ACT_CLOSE  = 3'd2,
    ACT_SET    = 3'd3,
    ACT_GET    = 3'd4,
    ACT_TICK   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RATE    = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_THERMAL_CAP = 2'd0,
    CFG_LATENCY     = 2'd1,
    CFG_RATE_ON     = 2'd2,
    CFG_LEVELS      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  client;
    logic [3:0]  level_index;
    logic [31:0] value_khz;
    logic        downstream_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_index;
    logic        request_valid;
    logic [31:0] request_khz;
    logic [31:0] applied_khz;
  } out_item_t;

endpackage

FILE: src/frequency_vote_aggregator.sv
// Frequency vote aggregator. Pulse start while busy is low to hand over one
// item; busy stays high while the sequencer works, and exactly one result
// appears on out_item for a single cycle with out_valid high, in the cycle
// busy drops. The receiver cannot stall, so capture it then. Table writes,
// opens, ticks and rejected actions finish in S_EXEC; a set level is refused
// in S_SET_CHK for an empty table entry. Close and an accepted set level walk
// the client slots with one comparator, one per cycle, then cap and decide;
// get level reads the level table RAM and compares one entry at a time,
// alternating a read state and a compare state. Configuration writes through
// cfg_we take effect at once and must only happen while idle.
module frequency_vote_aggregator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fva_pkg::in_item_t in_item,
  output logic              out_valid,
  output fva_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import fva_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EXEC    = 8'b0000_0010,
    S_SET_CHK = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_CAP     = 8'b0001_0000,
    S_DECIDE  = 8'b0010_0000,
    S_GET_RD  = 8'b0100_0000,
    S_GET_CMP = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic any_r, any_nxt;
  logic [31:0] max_r, max_nxt;
  logic [1:0] status_r, status_nxt;
  logic [3:0] found_r, found_nxt;
  logic req_valid_r, req_valid_nxt;
  logic [31:0] req_khz_r, req_khz_nxt;
  logic out_valid_r, out_valid_nxt;
  logic is_close_r, is_close_nxt;
  logic [31:0] applied_r, applied_nxt;
  logic changed_r, changed_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [CLIENTS-1:0] slot_open_r, slot_open_nxt;
  logic [31:0] slot_vote_r [CLIENTS];

  logic [31:0] cap_r;
  logic [31:0] latency_r;
  logic rate_on_r;
  logic [4:0] levels_r;

  logic vote_we;
  logic [CIDX_W-1:0] vote_idx;
  logic [31:0] vote_data;

  logic ram_we;
  logic [LIDX_W-1:0] ram_raddr;
  logic [31:0] ram_rdata;

  logic [CNT_W-1:0] lv;
  logic [CIDX_W-1:0] ci;
  logic client_ok;
  logic accept;
  logic [31:0] scan_vote;
  logic [1:0] upd_status;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Table entries beyond LEVELS count as absent.
  assign lv = (32'(levels_r) > 32'(LEVELS)) ? CNT_W'(LEVELS) : CNT_W'(levels_r);
  assign ci = CIDX_W'(item_r.client);
  assign client_ok = 32'(item_r.client) < 32'(CLIENTS);
  assign scan_vote = slot_vote_r[cnt_r[CIDX_W-1:0]];

  fva_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_level_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (LIDX_W'(item_r.level_index)),
    .wdata (item_r.value_khz),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    any_nxt       = any_r;
    max_nxt       = max_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    req_valid_nxt = req_valid_r;
    req_khz_nxt   = req_khz_r;
    out_valid_nxt = 1'b0;
    is_close_nxt  = is_close_r;
    applied_nxt   = applied_r;
    changed_nxt   = changed_r;
    elapsed_nxt   = elapsed_r;
    slot_open_nxt = slot_open_r;
    vote_we       = 1'b0;
    vote_idx      = ci;
    vote_data     = '0;
    ram_we        = 1'b0;
    ram_raddr     = LIDX_W'(item_r.level_index);
    upd_status    = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt      = in_item;
          status_nxt    = ST_OK;
          found_nxt     = '0;
          req_valid_nxt = 1'b0;
          req_khz_nxt   = '0;
          is_close_nxt  = (in_item.action == ACT_CLOSE);
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (item_r.action)
          ACT_TBL_WR: begin
            if (32'(item_r.level_index) < 32'(LEVELS)) begin
              ram_we = 1'b1;
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          ACT_OPEN: begin
            if (!client_ok || slot_open_r[ci]) begin
              status_nxt = ST_INVALID;
            end else begin
              slot_open_nxt[ci] = 1'b1;
              vote_we           = 1'b1;
            end
          end
          ACT_CLOSE: begin
            if (!client_ok || !slot_open_r[ci]) begin
              status_nxt = ST_INVALID;
            end else begin
              slot_open_nxt[ci] = 1'b0;
              vote_we           = 1'b1;
              cnt_nxt           = '0;
              any_nxt           = 1'b0;
              max_nxt           = '0;
              out_valid_nxt     = 1'b0;
              state_nxt         = S_SCAN;
            end
          end
          ACT_SET: begin
            if (!client_ok || !slot_open_r[ci] ||
                32'(item_r.level_index) >= 32'(lv)) begin
              status_nxt = ST_INVALID;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_SET_CHK;
            end
          end
          ACT_GET: begin
            if (lv == '0) begin
              status_nxt = ST_INVALID;
            end else begin
              cnt_nxt       = '0;
              out_valid_nxt = 1'b0;
              state_nxt     = S_GET_RD;
            end
          end
          ACT_TICK: begin
            if (elapsed_r != U32_MAX) begin
              elapsed_nxt = elapsed_r + 32'd1;
            end
          end
          default: begin
            status_nxt = ST_INVALID;
          end
        endcase
      end
      S_SET_CHK: begin
        if (ram_rdata == '0) begin
          status_nxt    = ST_INVALID;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          vote_we   = 1'b1;
          vote_data = ram_rdata;
          cnt_nxt   = '0;
          any_nxt   = 1'b0;
          max_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (slot_open_r[cnt_r[CIDX_W-1:0]]) begin
          any_nxt = 1'b1;
          if (scan_vote > max_r) begin
            max_nxt = scan_vote;
          end
        end
        if (cnt_r == CNT_W'(CLIENTS - 1)) begin
          state_nxt = S_CAP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_CAP: begin
        if (max_r > cap_r) begin
          max_nxt = cap_r;
        end
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!any_r) begin
          applied_nxt = '0;
        end else if (max_r == applied_r) begin
          upd_status = ST_OK;
        end else if (rate_on_r && changed_r && elapsed_r < latency_r) begin
          upd_status = ST_RATE;
        end else begin
          req_valid_nxt = 1'b1;
          req_khz_nxt   = max_r;
          if (!item_r.downstream_ok) begin
            upd_status = ST_FAILED;
          end else begin
            applied_nxt = max_r;
            changed_nxt = 1'b1;
            elapsed_nxt = '0;
          end
        end
        // close reports ok whatever the downstream did
        status_nxt    = is_close_r ? ST_OK : upd_status;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_GET_RD: begin
        ram_raddr = cnt_r[LIDX_W-1:0];
        state_nxt = S_GET_CMP;
      end
      S_GET_CMP: begin
        if (ram_rdata == item_r.value_khz) begin
          found_nxt     = 4'(cnt_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if ((cnt_r + CNT_W'(1)) == lv) begin
          status_nxt    = ST_INVALID;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_GET_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      applied_r   <= '0;
      changed_r   <= 1'b0;
      elapsed_r   <= '0;
      slot_open_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      applied_r   <= applied_nxt;
      changed_r   <= changed_nxt;
      elapsed_r   <= elapsed_nxt;
      slot_open_r <= slot_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    cnt_r       <= cnt_nxt;
    any_r       <= any_nxt;
    max_r       <= max_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    req_valid_r <= req_valid_nxt;
    req_khz_r   <= req_khz_nxt;
    is_close_r  <= is_close_nxt;
    if (vote_we) begin
      slot_vote_r[vote_idx] <= vote_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= U32_MAX;
      latency_r <= LATENCY_RST;
      rate_on_r <= 1'b0;
      levels_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THERMAL_CAP: cap_r     <= cfg_data;
        CFG_LATENCY:     latency_r <= cfg_data;
        CFG_RATE_ON:     rate_on_r <= cfg_data[0];
        CFG_LEVELS:      levels_r  <= cfg_data[4:0];
        default:         levels_r  <= levels_r;
      endcase
    end
  end

  assign out_valid                = out_valid_r;
  assign out_item.status          = status_r;
  assign out_item.found_index     = found_r;
  assign out_item.request_valid   = req_valid_r;
  assign out_item.request_khz     = req_khz_r;
  assign out_item.applied_khz     = applied_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_request_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.request_valid) |->
      (out_item.status != ST_INVALID && out_item.status != ST_RATE))
    else $error("request issued with a rejecting status");

  a_rate_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_RATE) |-> (rate_on_r && changed_r))
    else $error("rate limit reported while not armed");

endmodule

FILE: src/fva_ram.sv
module fva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fva_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 2 * LEVELS + 8;
  localparam logic [2:0]  ACT_UNDEF_LO = 3'd6;
  localparam logic [2:0]  ACT_UNDEF_HI = 3'd7;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  frequency_vote_aggregator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow of the block: registers and vote state.
  logic [31:0]        cap_khz    = U32_MAX;
  logic [31:0]        latency_us = LATENCY_RST;
  logic               limit_on   = 1'b0;
  logic [4:0]         levels_cfg = '0;
  logic [31:0]        tbl_khz [LEVELS] = '{default: '0};
  logic [CLIENTS-1:0] slot_on    = '0;
  logic [31:0]        slot_khz [CLIENTS] = '{default: '0};
  logic [31:0]        cur_applied = '0;
  logic               had_success = 1'b0;
  logic [31:0]        us_since_success = '0;

  out_item_t awaited_outcomes [$];
  out_item_t want;
  int        mismatches = 0;
  int        outcomes_checked = 0;
  int        items_sent = 0;
  int        requests_issued = 0;
  int        reg_writes = 0;
  int        status_count [4] = '{default: 0};
  int        cycle_count = 0;
  int        burst_left = 0;
  logic      gaps_on = 1'b1;

  function automatic int levels_usable();
    return (int'(levels_cfg) > LEVELS) ? LEVELS : int'(levels_cfg);
  endfunction

  // Max over open slots, capped; issue a request only on change.
  function automatic status_t settle_target(input logic ok, output logic rv,
                                            output logic [31:0] rk);
    logic        any;
    logic [31:0] tgt;
    int          i;
    any = 1'b0;
    tgt = '0;
    rv  = 1'b0;
    rk  = '0;
    for (i = 0; i < CLIENTS; i++) begin
      if (slot_on[i]) begin
        any = 1'b1;
        if (slot_khz[i] > tgt) tgt = slot_khz[i];
      end
    end
    if (!any) begin
      cur_applied = '0;
      return ST_OK;
    end
    if (tgt > cap_khz) tgt = cap_khz;
    if (tgt == cur_applied) return ST_OK;
    if (limit_on && had_success && us_since_success < latency_us) return ST_RATE;
    rv = 1'b1;
    rk = tgt;
    if (!ok) return ST_FAILED;
    cur_applied      = tgt;
    had_success      = 1'b1;
    us_since_success = '0;
    return ST_OK;
  endfunction

  function automatic out_item_t vote_outcome(input in_item_t it);
    out_item_t   r;
    int          i;
    int          lv;
    logic        rv;
    logic [31:0] rk;
    r  = '0;
    rv = 1'b0;
    rk = '0;
    r.status = ST_OK;
    lv = levels_usable();
    case (it.action)
      ACT_TBL_WR: begin
        if (int'(it.level_index) < LEVELS) tbl_khz[it.level_index] = it.value_khz;
        else r.status = ST_INVALID;
      end
      ACT_OPEN: begin
        if (slot_on[it.client]) begin
          r.status = ST_INVALID;
        end else begin
          slot_on[it.client]  = 1'b1;
          slot_khz[it.client] = '0;
        end
      end
      ACT_CLOSE: begin
        if (!slot_on[it.client]) begin
          r.status = ST_INVALID;
        end else begin
          slot_on[it.client]  = 1'b0;
          slot_khz[it.client] = '0;
          // close reports ok even when the request is refused or limited
          void'(settle_target(it.downstream_ok, rv, rk));
        end
      end
      ACT_SET: begin
        if (!slot_on[it.client] || int'(it.level_index) >= lv ||
            tbl_khz[it.level_index] == '0) begin
          r.status = ST_INVALID;
        end else begin
          slot_khz[it.client] = tbl_khz[it.level_index];
          r.status = settle_target(it.downstream_ok, rv, rk);
        end
      end
      ACT_GET: begin
        r.status = ST_INVALID;
        for (i = 0; i < lv; i++) begin
          if (r.status == ST_INVALID && tbl_khz[i] == it.value_khz) begin
            r.status      = ST_OK;
            r.found_index = i[3:0];
          end
        end
      end
      ACT_TICK: begin
        if (us_since_success != U32_MAX) us_since_success = us_since_success + 1;
      end
      default: r.status = ST_INVALID;
    endcase
    r.request_valid = rv;
    r.request_khz   = rk;
    r.applied_khz   = cur_applied;
    status_count[r.status]++;
    if (rv) requests_issued++;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, got 0x%0h",
                 $time, out_item);
      end else begin
        want = awaited_outcomes.pop_front();
        outcomes_checked++;
        check_field("status", 32'(want.status), 32'(out_item.status));
        check_field("found_index", 32'(want.found_index), 32'(out_item.found_index));
        check_field("request_valid", 32'(want.request_valid),
                    32'(out_item.request_valid));
        check_field("request_khz", want.request_khz, out_item.request_khz);
        check_field("applied_khz", want.applied_khz, out_item.applied_khz);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               awaited_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t mk(input logic [2:0] act, input int c, input int idx,
                                  input logic [31:0] f, input logic ok);
    in_item_t it;
    it.action        = act;
    it.client        = c[2:0];
    it.level_index   = idx[3:0];
    it.value_khz     = f;
    it.downstream_ok = ok;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_outcomes.push_back(vote_outcome(it));
    items_sent++;
  endtask

  // Send, then maybe idle: bursts of random length with random gaps.
  task automatic issue(input in_item_t it);
    int gap;
    send_item(it);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Hold the sender until every expected result is in and the block is idle.
  task automatic drain_outcomes();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_THERMAL_CAP: cap_khz    = val;
      CFG_LATENCY:     latency_us = val;
      CFG_RATE_ON:     limit_on   = val[0];
      CFG_LEVELS:      levels_cfg = val[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_khz();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return U32_MAX;
      2, 3:    return $urandom;
      4:       return tbl_khz[$urandom_range(0, LEVELS - 1)];
      default: return 32'd100000 * $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int pick_open_client();
    int cands [$];
    int i;
    for (i = 0; i < CLIENTS; i++) if (slot_on[i]) cands.push_back(i);
    if (cands.size() == 0 || $urandom_range(0, 6) == 0) return $urandom_range(0, CLIENTS - 1);
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       lv;
    lv = levels_usable();
    it = mk(ACT_TICK, $urandom_range(0, 7), $urandom_range(0, 15), $urandom,
            $urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      it.action = ACT_TICK;
    end else if (pick < 52) begin
      it.action = ACT_SET;
      it.client = 3'(pick_open_client());
      if (lv > 0 && $urandom_range(0, 5) != 0) it.level_index = 4'($urandom_range(0, lv - 1));
    end else if (pick < 62) begin
      it.action = ACT_OPEN;
    end else if (pick < 72) begin
      it.action = ACT_CLOSE;
      it.client = 3'(pick_open_client());
    end else if (pick < 86) begin
      it.action = ACT_GET;
      if (lv > 0 && $urandom_range(0, 3) != 0) it.value_khz = tbl_khz[$urandom_range(0, lv - 1)];
    end else if (pick < 96) begin
      it.action    = ACT_TBL_WR;
      it.value_khz = pick_khz();
    end else begin
      it.action = ($urandom_range(0, 1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
    end
    return it;
  endfunction

  task automatic test_undefined_actions();
    write_reg(CFG_LEVELS, 32'd0);
    issue(mk(ACT_GET, 0, 0, '0, 1'b1));
    issue(mk(ACT_UNDEF_LO, 0, 0, '0, 1'b0));
    issue(mk(ACT_UNDEF_HI, 7, 15, U32_MAX, 1'b1));
  endtask

  task automatic test_vote_basics();
    drain_outcomes();
    write_reg(CFG_LEVELS, 32'd6);
    issue(mk(ACT_TBL_WR, 0, 0, 32'd300000, 1'b1));
    issue(mk(ACT_TBL_WR, 0, 1, 32'd600000, 1'b1));
    issue(mk(ACT_TBL_WR, 0, 2, 32'd0, 1'b1));
    issue(mk(ACT_TBL_WR, 0, 3, U32_MAX, 1'b1));
    issue(mk(ACT_TBL_WR, 0, 4, 32'd600000, 1'b1));
    issue(mk(ACT_TBL_WR, 0, 5, 32'd1200000, 1'b1));
    issue(mk(ACT_OPEN, 0, 0, '0, 1'b1));
    issue(mk(ACT_OPEN, 0, 0, '0, 1'b1));
    issue(mk(ACT_SET, 0, 6, '0, 1'b1));
    issue(mk(ACT_SET, 0, 2, '0, 1'b1));
    issue(mk(ACT_SET, 0, 1, '0, 1'b0));
    issue(mk(ACT_SET, 0, 1, '0, 1'b1));
    issue(mk(ACT_OPEN, 7, 0, '0, 1'b1));
    issue(mk(ACT_SET, 7, 3, '0, 1'b1));
    // duplicate entry: first match must win
    issue(mk(ACT_GET, 0, 0, 32'd600000, 1'b1));
    issue(mk(ACT_GET, 0, 0, 32'd12345, 1'b1));
    issue(mk(ACT_CLOSE, 7, 0, '0, 1'b1));
    issue(mk(ACT_CLOSE, 0, 0, '0, 1'b1));
  endtask

  task automatic test_thermal_cap();
    drain_outcomes();
    write_reg(CFG_THERMAL_CAP, 32'd0);
    issue(mk(ACT_OPEN, 2, 0, '0, 1'b1));
    issue(mk(ACT_SET, 2, 5, '0, 1'b1));
    drain_outcomes();
    write_reg(CFG_THERMAL_CAP, 32'd500000);
    issue(mk(ACT_SET, 2, 5, '0, 1'b1));
    drain_outcomes();
    write_reg(CFG_THERMAL_CAP, U32_MAX);
    issue(mk(ACT_CLOSE, 2, 0, '0, 1'b1));
  endtask

  task automatic test_rate_limit();
    drain_outcomes();
    write_reg(CFG_RATE_ON, 32'd1);
    write_reg(CFG_LATENCY, 32'd3);
    issue(mk(ACT_OPEN, 4, 0, '0, 1'b1));
    repeat (3) issue(mk(ACT_TICK, 0, 0, '0, 1'b1));
    issue(mk(ACT_SET, 4, 0, '0, 1'b1));
    issue(mk(ACT_SET, 4, 5, '0, 1'b1));
    drain_outcomes();
    write_reg(CFG_LATENCY, 32'd0);
    issue(mk(ACT_SET, 4, 5, '0, 1'b1));
    issue(mk(ACT_OPEN, 5, 0, '0, 1'b1));
    issue(mk(ACT_CLOSE, 4, 0, '0, 1'b0));
    issue(mk(ACT_CLOSE, 5, 0, '0, 1'b1));
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    logic [31:0] cap;
    logic [31:0] lat;
    logic        on;
    logic [4:0]  lv;
    // fill the whole table before any phase widens the levels in use (levels_cfg)
    for (n = 0; n < LEVELS; n++)
      issue(mk(ACT_TBL_WR, $urandom_range(0, 7), n, pick_khz(), 1'($urandom_range(0, 1))));
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cap = U32_MAX; lat = LATENCY_RST; on = 1'b0; lv = 5'd16; end
        1: begin cap = $urandom_range(1, 4000000); lat = $urandom_range(2, 12); on = 1'b1;
                 lv = 5'd31; end
        2: begin cap = '0; lat = '0; on = 1'b1; lv = 5'($urandom_range(1, 15)); end
        3: begin cap = U32_MAX; lat = U32_MAX; on = 1'b1; lv = 5'd16; end
        4: begin cap = $urandom; lat = $urandom_range(1, 30); on = 1'b1;
                 lv = 5'($urandom_range(17, 30)); end
        default: begin cap = U32_MAX; lat = $urandom_range(0, 8);
                       on = 1'($urandom_range(0, 1)); lv = 5'd16; end
      endcase
      drain_outcomes();
      write_reg(CFG_THERMAL_CAP, cap);
      write_reg(CFG_LATENCY, lat);
      write_reg(CFG_RATE_ON, {31'd0, on});
      write_reg(CFG_LEVELS, {27'd0, lv});
      gaps_on = (phase != 2);
      for (n = 0; n < 80; n++) begin
        issue(random_item());
        if ($urandom_range(0, 59) == 0) drain_outcomes();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_undefined_actions();
    test_vote_basics();
    test_thermal_cap();
    test_rate_limit();
    test_random_traffic();
    drain_outcomes();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d items and %0d register writes; checked %0d results, %0d requests",
             items_sent, reg_writes, outcomes_checked, requests_issued);
    $display("Status mix: ok %0d, invalid %0d, rate limited %0d, downstream failed %0d",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
